// ===== rtl/csd_pkg.sv =====
// csd_pkg: shared types and codes for the compact size decoder
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package csd_pkg;

    // input transaction: one raw buffer byte and how many bytes follow it
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] bytes_after;
    } csd_in_t;

    // result transaction
    typedef struct packed {
        logic [63:0] count_value;
        logic [2:0]  status;
    } csd_out_t;

    // classified work handed from the front end to the back end
    typedef struct packed {
        logic [63:0] value;
        logic [63:0] remaining;
        logic [2:0]  status;
        logic        check;
    } csd_job_t;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TRUNC    = 3'd1;
    localparam logic [2:0] ST_NONCANON = 3'd2;
    localparam logic [2:0] ST_EXCEEDS  = 3'd3;
    localparam logic [2:0] ST_ZEROMIN  = 3'd4;

    localparam logic [7:0] TAG_U16 = 8'hFD;
    localparam logic [7:0] TAG_U32 = 8'hFE;
    localparam logic [7:0] TAG_U64 = 8'hFF;

    // width code of the prefix being collected
    localparam logic [1:0] FORM_2 = 2'd1;
    localparam logic [1:0] FORM_4 = 2'd2;
    localparam logic [1:0] FORM_8 = 2'd3;

    localparam logic [15:0] MIN_RESET = 16'd1;

endpackage

// ===== rtl/csd_front.sv =====
// csd_front: accepts bytes, tracks prefix collection and classifies each count
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_front #(
    parameter int REMAINING_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  csd_pkg::csd_in_t  in_item,
    input  logic [15:0]       min_bytes,
    output logic              job_valid,
    output csd_pkg::csd_job_t job
);
    import csd_pkg::*;

    localparam logic [63:0] REM_MASK =
        (REMAINING_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << REMAINING_WIDTH) - 64'd1);

    logic        collecting_reg, collecting_next;
    logic [3:0]  need_reg, need_next;
    logic [1:0]  form_reg, form_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  pos_reg, pos_next;

    logic [63:0] remaining;
    logic [63:0] acc_merged;
    logic [3:0]  need_dec;
    logic        canon;

    assign remaining = {32'd0, in_item.bytes_after} & REM_MASK;
    assign need_dec  = need_reg - 4'd1;

    always_comb
    begin
        acc_merged = acc_reg;
        acc_merged[pos_reg*8 +: 8] = in_item.data_byte;
    end

    always_comb
    begin
        case (form_reg)
            FORM_2:  canon = (acc_merged >= 64'hFD);
            FORM_4:  canon = (acc_merged > 64'hFFFF);
            default: canon = (acc_merged > 64'hFFFF_FFFF);
        endcase
    end

    always_comb
    begin
        collecting_next = collecting_reg;
        need_next       = need_reg;
        form_next       = form_reg;
        acc_next        = acc_reg;
        pos_next        = pos_reg;
        job_valid       = 1'b0;
        job             = '0;
        job.remaining   = remaining;
        if (accept)
        begin
            if (!collecting_reg)
            begin
                if (min_bytes == 16'd0)
                begin
                    job_valid  = 1'b1;
                    job.status = ST_ZEROMIN;
                end
                else if (in_item.data_byte < TAG_U16)
                begin
                    job_valid  = 1'b1;
                    job.value  = {56'd0, in_item.data_byte};
                    job.check  = 1'b1;
                end
                else
                begin
                    if (in_item.data_byte == TAG_U16)
                    begin
                        need_next = 4'd2;
                        form_next = FORM_2;
                    end
                    else if (in_item.data_byte == TAG_U32)
                    begin
                        need_next = 4'd4;
                        form_next = FORM_4;
                    end
                    else
                    begin
                        need_next = 4'd8;
                        form_next = FORM_8;
                    end
                    if (remaining < {60'd0, need_next})
                    begin
                        job_valid  = 1'b1;
                        job.status = ST_TRUNC;
                        need_next  = 4'd0;
                        form_next  = 2'd0;
                    end
                    else
                    begin
                        collecting_next = 1'b1;
                        acc_next        = '0;
                        pos_next        = 3'd0;
                    end
                end
            end
            else
            begin
                acc_next  = acc_merged;
                pos_next  = pos_reg + 3'd1;
                need_next = need_dec;
                if (need_dec == 4'd0)
                begin
                    job_valid       = 1'b1;
                    collecting_next = 1'b0;
                    form_next       = 2'd0;
                    acc_next        = '0;
                    pos_next        = 3'd0;
                    if (!canon)
                        job.status = ST_NONCANON;
                    else if (min_bytes == 16'd0)
                        job.status = ST_ZEROMIN;
                    else
                    begin
                        job.value = acc_merged;
                        job.check = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            need_reg       <= 4'd0;
            form_reg       <= 2'd0;
            acc_reg        <= '0;
            pos_reg        <= 3'd0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            need_reg       <= need_next;
            form_reg       <= form_next;
            acc_reg        <= acc_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

// ===== rtl/csd_queue.sv =====
// csd_queue: two-entry queue of classified jobs between front and back end
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  csd_pkg::csd_job_t wr_job,
    input  logic              rd_en,
    output csd_pkg::csd_job_t rd_job,
    output logic              q_full,
    output logic              q_empty
);
    import csd_pkg::*;

    csd_job_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/csd_back.sv =====
// csd_back: bound check by chunked multiply-accumulate and the result register
// depends on csd_pkg
`timescale 1ns / 1ps

module csd_back #(
    parameter int REMAINING_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_avail,
    input  csd_pkg::csd_job_t job,
    output logic              job_take,
    input  logic [15:0]       min_bytes,
    input  logic              pop,
    output logic              empty,
    output csd_pkg::csd_out_t out_item
);
    import csd_pkg::*;

    localparam int NCHUNK = (REMAINING_WIDTH + 15) / 16;
    localparam int PW     = NCHUNK * 16;
    localparam int PRW    = PW + 16;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [63:0] REM_MASK =
        (REMAINING_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << REMAINING_WIDTH) - 64'd1);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_MUL  = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    csd_out_t    res_reg, res_next;
    logic [PW-1:0]  mval_reg, mval_next;
    logic [PW-1:0]  rem_reg, rem_next;
    logic [PRW-1:0] prod_reg, prod_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           out_valid_reg, out_valid_next;
    csd_out_t       out_reg, out_next;
    logic [31:0]    part;
    logic [PRW-1:0] prod_sum;
    logic           slot_free;

    assign empty     = !out_valid_reg;
    assign out_item  = out_reg;
    assign slot_free = !out_valid_reg || pop;

    assign part     = mval_reg[PW-1 -: 16] * min_bytes;
    assign prod_sum = (prod_reg << 16) + PRW'(part);

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        mval_next      = mval_reg;
        rem_next       = rem_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        job_take       = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (job_avail)
                begin
                    job_take = 1'b1;
                    if (!job.check)
                    begin
                        res_next.count_value = '0;
                        res_next.status      = job.status;
                        state_next           = B_DONE;
                    end
                    else if ((job.value & ~REM_MASK) != 64'd0)
                    begin
                        // count wider than any remaining figure, minimum is nonzero
                        res_next.count_value = '0;
                        res_next.status      = ST_EXCEEDS;
                        state_next           = B_DONE;
                    end
                    else
                    begin
                        res_next.count_value = job.value;
                        res_next.status      = ST_OK;
                        mval_next            = job.value[PW-1:0];
                        rem_next             = job.remaining[PW-1:0];
                        prod_next            = '0;
                        cnt_next             = CW'(NCHUNK - 1);
                        state_next           = B_MUL;
                    end
                end
            end
            B_MUL:
            begin
                prod_next = prod_sum;
                mval_next = mval_reg << 16;
                cnt_next  = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    if (prod_sum > {16'd0, rem_reg})
                    begin
                        res_next.count_value = '0;
                        res_next.status      = ST_EXCEEDS;
                    end
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        mval_reg <= mval_next;
        rem_reg  <= rem_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/compact_size_decoder.sv =====
// compact_size_decoder: top level of the variable-length count decoder
// depends on csd_pkg, csd_front, csd_queue and csd_back
`timescale 1ns / 1ps

// Decodes variable-length counts from a byte stream, one byte per input
// transaction, each tagged with the number of buffer bytes after it. A tag
// below 0xFD is the count; 0xFD, 0xFE and 0xFF introduce a 2-, 4- or 8-byte
// little-endian count. Results report ok, truncated prefix, non-canonical
// encoding, count exceeding the remaining bytes over the minimum element
// size, or a zero minimum; count_value is zero on any failure. The front end
// takes one byte per cycle whenever full is low and hands each finished
// prefix to a two-entry job queue. The back end checks the bound with a
// 16x16 multiply-accumulate, one 16-bit chunk of the count per cycle, and
// takes the next job only after its result is in the output register;
// error results skip the multiply. Meanwhile the front end goes on taking
// bytes while the queue has room. The minimum element size resets to 1
// and may be rewritten only while idle.

module compact_size_decoder #(
    parameter int REMAINING_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    // input transactions
    input  logic              push,
    output logic              full,
    input  csd_pkg::csd_in_t  in_item,
    // result transactions
    output logic              empty,
    input  logic              pop,
    output csd_pkg::csd_out_t out_item,
    // minimum element size write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);
    import csd_pkg::*;

    logic [15:0] min_bytes_reg, min_bytes_next;
    logic        accept;
    logic        job_valid;
    csd_job_t    front_job;
    csd_job_t    queue_job;
    logic        job_take;
    logic        q_full;
    logic        q_empty;

    // register write always taken
    assign cfg_ready = 1'b1;
    assign min_bytes_next = (cfg_valid && cfg_ready) ? cfg_data : min_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_bytes_reg <= MIN_RESET;
        else
            min_bytes_reg <= min_bytes_next;
    end

    // a byte is taken only while the job queue has room for what it may produce
    assign full   = q_full;
    assign accept = push && !q_full;

    csd_front #(
        .REMAINING_WIDTH(REMAINING_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .min_bytes (min_bytes_reg),
        .job_valid (job_valid),
        .job       (front_job)
    );

    // decouples byte intake from the bound check
    csd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_job  (front_job),
        .rd_en   (job_take),
        .rd_job  (queue_job),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // bound check and result register
    csd_back #(
        .REMAINING_WIDTH(REMAINING_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (!q_empty),
        .job       (queue_job),
        .job_take  (job_take),
        .min_bytes (min_bytes_reg),
        .pop       (pop),
        .empty     (empty),
        .out_item  (out_item)
    );

endmodule
